@@ hdl/tse_pkg.sv @@
// tse_pkg: shared types and constants of the topological sort engine
// no dependencies; imported by the interfaces and the top level

package tse_pkg;

    localparam int NODE_W = 7;
    localparam int DEG_W  = 11;
    localparam int STAT_W = 2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [DEG_W-1:0]  deg_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam node_t NODE_COUNT_RST = 7'd64;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    localparam status_t ST_SORTED = 2'd0;
    localparam status_t ST_CYCLE  = 2'd1;
    localparam status_t ST_REJECT = 2'd2;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_ADD_RD   = 13'b0000000000010,
        S_ADD_WR   = 13'b0000000000100,
        S_SEED_RD  = 13'b0000000001000,
        S_SEED_CHK = 13'b0000000010000,
        S_POP      = 13'b0000000100000,
        S_HEAD     = 13'b0000001000000,
        S_LINK     = 13'b0000010000000,
        S_EDGE     = 13'b0000100000000,
        S_DEG      = 13'b0001000000000,
        S_EMIT_RD  = 13'b0010000000000,
        S_EMIT_LD  = 13'b0100000000000,
        S_EMIT_OUT = 13'b1000000000000
    } seq_state_t;

endpackage

@@ hdl/tse_if.sv @@
// tse_if: valid/ready channels for requests, results and configuration
// depends on tse_pkg

interface tse_req_if;
    import tse_pkg::*;
    logic  valid;
    logic  ready;
    logic  req_type;
    node_t src_node;
    node_t dst_node;
    modport source (output valid, output req_type, output src_node, output dst_node,
                    input ready);
    modport sink (input valid, input req_type, input src_node, input dst_node,
                  output ready);
endinterface

interface tse_res_if;
    import tse_pkg::*;
    logic    valid;
    logic    ready;
    node_t   node_id;
    logic    node_valid;
    logic    last;
    status_t status;
    modport source (output valid, output node_id, output node_valid, output last,
                    output status, input ready);
    modport sink (input valid, input node_id, input node_valid, input last,
                  input status, output ready);
endinterface

interface tse_cfg_if;
    import tse_pkg::*;
    logic  valid;
    logic  ready;
    node_t node_count;
    modport source (output valid, output node_count, input ready);
    modport sink (input valid, input node_count, output ready);
endinterface

@@ hdl/tse_ram.sv @@
// tse_ram: generic single-write, single-read memory with registered read data
// no dependencies

module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/topological_sort_engine.sv @@
// topological_sort_engine: Kahn topological sort over linked edge lists
// depends on tse_pkg, tse_if (channels) and tse_ram (edge, head, degree, queue stores)
// an add-edge transaction reads the source head and target degree, then writes the edge
// entry, head and degree; a run seeds the queue from the degree of every node, walks the
// edge list of each popped node through the single degree-memory read/modify/write path
// throughput: one transaction at a time; not ready while a run or add is in progress
// reset: rst_n clears control, counters and entry valid bits; node_count returns to 64

module topological_sort_engine #(
    parameter int NODES = 64,
    parameter int EDGES = 1024
) (
    input logic    clk,
    input logic    rst_n,
    tse_cfg_if.sink cfg,
    tse_req_if.sink req,
    tse_res_if.source res
);
    import tse_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int QW    = $clog2(NODES + 1);
    localparam int EW    = $clog2(EDGES);
    localparam int FW    = $clog2(EDGES + 1);
    localparam int ENT_W = 1 + EW + NODE_W;

    localparam node_t           NODES_N  = NODE_W'(NODES);
    localparam logic [FW-1:0]   FILL_MAX = FW'(EDGES);
    localparam logic [QW-1:0]   Q_MAX    = QW'(NODES);

    // control state
    seq_state_t        state_reg, state_next;
    node_t             node_count_reg, node_count_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [QW-1:0]     q_rd_reg, q_rd_next;
    logic [QW-1:0]     q_wr_reg, q_wr_next;
    logic [QW-1:0]     emit_reg, emit_next;
    node_t             scan_reg, scan_next;
    logic              reject_reg, reject_next;
    logic [NODES-1:0]  head_vld_reg, head_vld_next;
    logic [NODES-1:0]  deg_vld_reg, deg_vld_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [NW-1:0]     src_idx_reg, src_idx_next;
    node_t             dst_reg, dst_next;
    node_t             vnode_reg, vnode_next;
    logic              vok_reg, vok_next;
    logic [EW-1:0]     nxt_reg, nxt_next;
    logic              nxt_null_reg, nxt_null_next;
    logic [NW-1:0]     head_ridx_reg;
    logic [NW-1:0]     deg_ridx_reg;
    node_t             out_id_reg, out_id_next;
    logic              out_nv_reg, out_nv_next;
    logic              out_last_reg, out_last_next;
    status_t           out_status_reg, out_status_next;

    // memory ports
    logic              head_we, deg_we, q_we, edge_we;
    logic [NW-1:0]     head_waddr, head_raddr, deg_waddr, deg_raddr, q_waddr, q_raddr;
    logic [EW-1:0]     head_wdata, head_rdata, edge_waddr, edge_raddr;
    deg_t              deg_wdata, deg_rdata;
    node_t             q_wdata, q_rdata;
    logic [ENT_W-1:0]  edge_wdata, edge_rdata;

    // helpers
    node_t             n_act;
    node_t             src_m1, dst_m1, u_m1, v_m1, v_node;
    deg_t              deg_eff;
    logic              add_bad;
    status_t           run_status;
    logic              emit_last;

    tse_ram #(.WIDTH(EW), .DEPTH(NODES)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    tse_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    tse_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    tse_ram #(.WIDTH(ENT_W), .DEPTH(EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_act = NODE_W'(1);
        end
        else if (node_count_reg > NODES_N)
        begin
            n_act = NODES_N;
        end
        else
        begin
            n_act = node_count_reg;
        end
    end

    assign src_m1   = req.src_node - NODE_W'(1);
    assign dst_m1   = dst_reg - NODE_W'(1);
    assign u_m1     = q_rdata - NODE_W'(1);
    assign v_node   = edge_rdata[NODE_W-1:0];
    assign v_m1     = v_node - NODE_W'(1);
    assign deg_eff  = deg_vld_reg[deg_ridx_reg] ? deg_rdata : '0;

    assign add_bad = (req.src_node == '0) || (req.src_node > n_act) ||
                     (req.dst_node == '0) || (req.dst_node > n_act) ||
                     (fill_reg == FILL_MAX);

    always_comb
    begin
        if (reject_reg)
        begin
            run_status = ST_REJECT;
        end
        else if (NODE_W'(q_wr_reg) != n_act)
        begin
            run_status = ST_CYCLE;
        end
        else
        begin
            run_status = ST_SORTED;
        end
    end

    assign emit_last = ((emit_reg + QW'(1)) == q_wr_reg);

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        fill_next       = fill_reg;
        q_rd_next       = q_rd_reg;
        q_wr_next       = q_wr_reg;
        emit_next       = emit_reg;
        scan_next       = scan_reg;
        reject_next     = reject_reg;
        head_vld_next   = head_vld_reg;
        deg_vld_next    = deg_vld_reg;
        out_valid_next  = out_valid_reg;
        src_idx_next    = src_idx_reg;
        dst_next        = dst_reg;
        vnode_next      = vnode_reg;
        vok_next        = vok_reg;
        nxt_next        = nxt_reg;
        nxt_null_next   = nxt_null_reg;
        out_id_next     = out_id_reg;
        out_nv_next     = out_nv_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        head_we    = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        head_raddr = '0;
        deg_we     = 1'b0;
        deg_waddr  = '0;
        deg_wdata  = '0;
        deg_raddr  = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_raddr    = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;

        if (cfg.valid)
        begin
            node_count_next = cfg.node_count;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (add_bad)
                            begin
                                reject_next = 1'b1;
                            end
                            else
                            begin
                                src_idx_next = src_m1[NW-1:0];
                                dst_next     = req.dst_node;
                                state_next   = S_ADD_RD;
                            end
                        end
                        REQ_RUN:
                        begin
                            scan_next  = '0;
                            q_rd_next  = '0;
                            q_wr_next  = '0;
                            state_next = S_SEED_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_RD:
            begin
                head_raddr = src_idx_reg;
                deg_raddr  = dst_m1[NW-1:0];
                state_next = S_ADD_WR;
            end

            S_ADD_WR:
            begin
                // push the new edge onto the front of the source list
                edge_we    = 1'b1;
                edge_waddr = fill_reg[EW-1:0];
                edge_wdata = {~head_vld_reg[head_ridx_reg], head_rdata, dst_reg};
                head_we    = 1'b1;
                head_waddr = head_ridx_reg;
                head_wdata = fill_reg[EW-1:0];
                head_vld_next[head_ridx_reg] = 1'b1;
                deg_we     = 1'b1;
                deg_waddr  = deg_ridx_reg;
                deg_wdata  = deg_eff + DEG_W'(1);
                deg_vld_next[deg_ridx_reg] = 1'b1;
                fill_next  = fill_reg + FW'(1);
                state_next = S_IDLE;
            end

            S_SEED_RD:
            begin
                deg_raddr  = scan_reg[NW-1:0];
                state_next = S_SEED_CHK;
            end

            S_SEED_CHK:
            begin
                if ((deg_eff == '0) && (q_wr_reg != Q_MAX))
                begin
                    q_we      = 1'b1;
                    q_waddr   = q_wr_reg[NW-1:0];
                    q_wdata   = scan_reg + NODE_W'(1);
                    q_wr_next = q_wr_reg + QW'(1);
                end
                if (scan_reg == (n_act - NODE_W'(1)))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    scan_next  = scan_reg + NODE_W'(1);
                    state_next = S_SEED_RD;
                end
            end

            S_POP:
            begin
                if (q_rd_reg == q_wr_reg)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    q_raddr    = q_rd_reg[NW-1:0];
                    q_rd_next  = q_rd_reg + QW'(1);
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                head_raddr = u_m1[NW-1:0];
                state_next = S_LINK;
            end

            S_LINK:
            begin
                if (head_vld_reg[head_ridx_reg])
                begin
                    edge_raddr = head_rdata;
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_POP;
                end
            end

            S_EDGE:
            begin
                deg_raddr     = v_m1[NW-1:0];
                vnode_next    = v_node;
                vok_next      = (v_node != '0) && (v_node <= n_act);
                nxt_next      = edge_rdata[ENT_W-2:NODE_W];
                nxt_null_next = edge_rdata[ENT_W-1];
                state_next    = S_DEG;
            end

            S_DEG:
            begin
                if (vok_reg && (deg_eff != '0))
                begin
                    deg_we    = 1'b1;
                    deg_waddr = deg_ridx_reg;
                    deg_wdata = deg_eff - DEG_W'(1);
                    deg_vld_next[deg_ridx_reg] = 1'b1;
                    if ((deg_eff == DEG_W'(1)) && (q_wr_reg != Q_MAX))
                    begin
                        q_we      = 1'b1;
                        q_waddr   = q_wr_reg[NW-1:0];
                        q_wdata   = vnode_reg;
                        q_wr_next = q_wr_reg + QW'(1);
                    end
                end
                if (nxt_null_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    edge_raddr = nxt_reg;
                    state_next = S_EDGE;
                end
            end

            S_EMIT_RD:
            begin
                if (q_wr_reg == '0)
                begin
                    // nothing emitted: a single closing result
                    out_id_next     = '0;
                    out_nv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    out_status_next = run_status;
                    out_valid_next  = 1'b1;
                    state_next      = S_EMIT_OUT;
                end
                else
                begin
                    q_raddr    = emit_reg[NW-1:0];
                    state_next = S_EMIT_LD;
                end
            end

            S_EMIT_LD:
            begin
                out_id_next     = q_rdata;
                out_nv_next     = 1'b1;
                out_last_next   = emit_last;
                out_status_next = emit_last ? run_status : ST_SORTED;
                out_valid_next  = 1'b1;
                state_next      = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        // run done: back to an empty graph
                        fill_next     = '0;
                        q_rd_next     = '0;
                        q_wr_next     = '0;
                        reject_next   = 1'b0;
                        head_vld_next = '0;
                        deg_vld_next  = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + QW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            fill_reg       <= '0;
            q_rd_reg       <= '0;
            q_wr_reg       <= '0;
            emit_reg       <= '0;
            scan_reg       <= '0;
            reject_reg     <= 1'b0;
            head_vld_reg   <= '0;
            deg_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            fill_reg       <= fill_next;
            q_rd_reg       <= q_rd_next;
            q_wr_reg       <= q_wr_next;
            emit_reg       <= emit_next;
            scan_reg       <= scan_next;
            reject_reg     <= reject_next;
            head_vld_reg   <= head_vld_next;
            deg_vld_reg    <= deg_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_idx_reg    <= src_idx_next;
        dst_reg        <= dst_next;
        vnode_reg      <= vnode_next;
        vok_reg        <= vok_next;
        nxt_reg        <= nxt_next;
        nxt_null_reg   <= nxt_null_next;
        head_ridx_reg  <= head_raddr;
        deg_ridx_reg   <= deg_raddr;
        out_id_reg     <= out_id_next;
        out_nv_reg     <= out_nv_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign cfg.ready      = 1'b1;
    assign req.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.node_id    = out_id_reg;
    assign res.node_valid = out_nv_reg;
    assign res.last       = out_last_reg;
    assign res.status     = out_status_reg;

endmodule
